// File: hw/rtl/puart_pkg.sv
// Shared types and constants for the UART port block with receive and transmit FIFOs.
// No dependencies; imported by puart_fifo, port_uart_with_fifos and the testbench.
package puart_pkg;

   typedef enum logic [1:0] {
      CMD_CPU_READ  = 2'd0,
      CMD_CPU_WRITE = 2'd1,
      CMD_HOST_RX   = 2'd2,
      CMD_HOST_PULL = 2'd3
   } command_type;

   localparam logic [15:0] PORT_STATUS = 16'h0040;
   localparam logic [15:0] PORT_DATA   = 16'h0041;

   localparam logic [7:0] STATUS_RX_EMPTY = 8'h01;
   localparam logic [7:0] STATUS_RX_FULL  = 8'h02;
   localparam logic [7:0] STATUS_TX_EMPTY = 8'h04;
   localparam logic [7:0] STATUS_TX_FULL  = 8'h08;
   localparam logic [7:0] READ_UNDECODED  = 8'hFF;
   localparam logic [7:0] NEWLINE_BYTE    = 8'h0A;

   typedef struct packed {
      logic empty;
      logic full;
      logic empty_in;
      logic full_in;
   } fifo_status_type;

endpackage

// File: hw/rtl/puart_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module puart_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/puart_fifo.sv
// Byte FIFO: head, tail and count registers over a puart_ram, with the head entry
// always presented. Depends on puart_pkg and puart_ram.
module puart_fifo
   import puart_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  logic [7:0]      push_data,
   input  logic            pop,
   output logic [7:0]      head_data,
   output fifo_status_type status
);

   localparam int PtrWidth   = $clog2(DEPTH);
   localparam int CountWidth = $clog2(DEPTH + 1);

   logic [PtrWidth-1:0]   head_ff, head_in;
   logic [PtrWidth-1:0]   tail_ff, tail_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  bypass_ff, bypass_in;
   logic [7:0]            bypass_data_ff;
   logic [7:0]            ram_rd_data;

   function automatic logic [PtrWidth-1:0] ptr_next(input logic [PtrWidth-1:0] ptr);
      logic [PtrWidth-1:0] result;
      if (ptr == PtrWidth'(DEPTH - 1)) begin
         result = '0;
      end else begin
         result = ptr + 1'b1;
      end
      return result;
   endfunction

   always_comb begin
      head_in  = pop ? ptr_next(head_ff) : head_ff;
      tail_in  = push ? ptr_next(tail_ff) : tail_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
      bypass_in = push && (tail_ff == head_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff   <= '0;
         tail_ff   <= '0;
         count_ff  <= '0;
         bypass_ff <= 1'b0;
      end else begin
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         count_ff  <= count_in;
         bypass_ff <= bypass_in;
      end
      bypass_data_ff <= push_data;
   end

   puart_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (tail_ff),
      .wr_data (push_data),
      .rd_addr (head_in),
      .rd_data (ram_rd_data)
   );

   assign head_data       = bypass_ff ? bypass_data_ff : ram_rd_data;
   assign status.empty    = (count_ff == '0);
   assign status.full     = (count_ff == CountWidth'(DEPTH));
   assign status.empty_in = (count_in == '0);
   assign status.full_in  = (count_in == CountWidth'(DEPTH));

endmodule

// File: hw/rtl/port_uart_with_fifos.sv
// UART behind two CPU I/O ports (status at 0x40, data at 0x41) with receive and transmit
// FIFOs of FIFO_DEPTH bytes. Every item (CPU read, CPU write, host byte, host pull) gives
// exactly one result. An item passes an input register, then decode and FIFO access, then
// the result register; one item per cycle is sustained while results are taken.
// Host bytes are dropped until the first newline, which is dropped as well.
// Depends on puart_pkg and puart_fifo.
module port_uart_with_fifos
   import puart_pkg::*;
#(
   parameter int FIFO_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [15:0] req_port_address,
   input  logic        req_is_io_space,
   input  logic [7:0]  req_write_byte,
   input  logic [7:0]  req_host_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_decoded_hit,
   output logic [7:0]  rsp_read_byte,
   output logic        rsp_write_accepted,
   output logic        rsp_host_byte_taken,
   output logic        rsp_tx_valid,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_rx_has_room,
   output logic        rsp_tx_pending
);

   logic        s1_valid_ff, s1_valid_in;
   logic [1:0]  s1_command_ff;
   logic [15:0] s1_address_ff;
   logic        s1_io_ff;
   logic [7:0]  s1_write_byte_ff;
   logic [7:0]  s1_host_byte_ff;
   logic        s1_advance, fire, req_take;

   logic        await_ff, await_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        hit_ff, hit_in;
   logic [7:0]  read_byte_ff, read_byte_in;
   logic        waccept_ff, waccept_in;
   logic        htaken_ff, htaken_in;
   logic        txv_ff, txv_in;
   logic [7:0]  txb_ff, txb_in;
   logic        rx_room_ff, rx_room_in;
   logic        tx_pending_ff, tx_pending_in;

   logic        decoded;
   logic        rx_push, rx_pop, tx_push, tx_pop;
   logic [7:0]  rx_head_data, tx_head_data;
   logic [7:0]  status_byte;
   fifo_status_type rx_status, tx_status;

   assign s1_advance = !rsp_valid_ff || rsp_ready;
   assign fire       = s1_valid_ff && s1_advance;
   assign req_ready  = !s1_valid_ff || s1_advance;
   assign req_take   = req_valid && req_ready;

   always_comb begin
      decoded = s1_io_ff && ((s1_address_ff == PORT_STATUS) || (s1_address_ff == PORT_DATA));

      status_byte = '0;
      if (rx_status.empty) begin
         status_byte = status_byte | STATUS_RX_EMPTY;
      end else if (rx_status.full) begin
         status_byte = status_byte | STATUS_RX_FULL;
      end
      if (tx_status.empty) begin
         status_byte = status_byte | STATUS_TX_EMPTY;
      end else if (tx_status.full) begin
         status_byte = status_byte | STATUS_TX_FULL;
      end

      hit_in       = 1'b0;
      read_byte_in = '0;
      waccept_in   = 1'b0;
      htaken_in    = 1'b0;
      txv_in       = 1'b0;
      txb_in       = '0;
      rx_push      = 1'b0;
      rx_pop       = 1'b0;
      tx_push      = 1'b0;
      tx_pop       = 1'b0;
      await_in     = await_ff;

      case (command_type'(s1_command_ff))
         CMD_CPU_READ: begin
            hit_in = decoded;
            if (!decoded) begin
               read_byte_in = READ_UNDECODED;
            end else if (s1_address_ff == PORT_STATUS) begin
               read_byte_in = status_byte;
            end else if (!rx_status.empty) begin
               read_byte_in = rx_head_data;
               rx_pop       = fire;
            end
         end
         CMD_CPU_WRITE: begin
            hit_in = decoded;
            if (decoded && (s1_address_ff == PORT_DATA) && !tx_status.full) begin
               waccept_in = 1'b1;
               tx_push    = fire;
            end
         end
         CMD_HOST_RX: begin
            if (!rx_status.full) begin
               htaken_in = 1'b1;
               if (await_ff) begin
                  if (s1_host_byte_ff == NEWLINE_BYTE) begin
                     await_in = 1'b0;
                  end
               end else begin
                  rx_push = fire;
               end
            end
         end
         CMD_HOST_PULL: begin
            if (!tx_status.empty) begin
               txv_in = 1'b1;
               txb_in = tx_head_data;
               tx_pop = fire;
            end
         end
         default: begin
            hit_in = 1'b0;
         end
      endcase

      rx_room_in    = !rx_status.full_in;
      tx_pending_in = !tx_status.empty_in;
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (fire) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         await_ff     <= 1'b1;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            await_ff <= await_in;
         end
      end
      if (req_take) begin
         s1_command_ff    <= req_command;
         s1_address_ff    <= req_port_address;
         s1_io_ff         <= req_is_io_space;
         s1_write_byte_ff <= req_write_byte;
         s1_host_byte_ff  <= req_host_byte;
      end
      if (fire) begin
         hit_ff        <= hit_in;
         read_byte_ff  <= read_byte_in;
         waccept_ff    <= waccept_in;
         htaken_ff     <= htaken_in;
         txv_ff        <= txv_in;
         txb_ff        <= txb_in;
         rx_room_ff    <= rx_room_in;
         tx_pending_ff <= tx_pending_in;
      end
   end

   puart_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_rx_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (rx_push),
      .push_data (s1_host_byte_ff),
      .pop       (rx_pop),
      .head_data (rx_head_data),
      .status    (rx_status)
   );

   puart_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_tx_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (tx_push),
      .push_data (s1_write_byte_ff),
      .pop       (tx_pop),
      .head_data (tx_head_data),
      .status    (tx_status)
   );

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_decoded_hit     = hit_ff;
   assign rsp_read_byte       = read_byte_ff;
   assign rsp_write_accepted  = waccept_ff;
   assign rsp_host_byte_taken = htaken_ff;
   assign rsp_tx_valid        = txv_ff;
   assign rsp_tx_byte         = txb_ff;
   assign rsp_rx_has_room     = rx_room_ff;
   assign rsp_tx_pending      = tx_pending_ff;

endmodule

// File: hw/rtl/puart_checker.sv
// Port-level assertions for port_uart_with_fifos, attached by the bind below.
// No dependencies beyond the top-level ports.
module puart_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_decoded_hit,
   input logic [7:0] rsp_read_byte,
   input logic       rsp_write_accepted,
   input logic       rsp_host_byte_taken,
   input logic       rsp_tx_valid,
   input logic [7:0] rsp_tx_byte,
   input logic       rsp_tx_pending
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_byte) && $stable(rsp_tx_byte))
      else $error("result item changed while stalled");

   a_one_effect: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0({rsp_write_accepted, rsp_host_byte_taken, rsp_tx_valid}))
      else $error("item reports more than one effect");

   a_tx_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_tx_valid |-> rsp_tx_byte == 8'h00)
      else $error("transmit byte nonzero without delivery");

   a_write_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_write_accepted |-> rsp_tx_pending && rsp_decoded_hit)
      else $error("accepted write left transmit FIFO empty");

   a_host_no_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_host_byte_taken || rsp_tx_valid) |->
         !rsp_decoded_hit && rsp_read_byte == 8'h00)
      else $error("host item reports CPU fields");

endmodule

bind port_uart_with_fifos puart_checker u_checker (.*);

// File: dv/port_uart_with_fifos_tb.sv
// Self-checking testbench for port_uart_with_fifos: CPU port reads and writes, host bytes
// and host pulls go through a valid/ready driver; results are checked against a predictor.
// Depends on puart_pkg and the port_uart_with_fifos RTL.
module port_uart_with_fifos_tb;
   import puart_pkg::*;

   localparam int DEPTH = 16;

   typedef struct packed {
      command_type cmd;
      logic [15:0] addr;
      logic        io;
      logic [7:0]  wbyte;
      logic [7:0]  hbyte;
      logic        hold_for_drain;
   } uart_request_type;

   typedef struct packed {
      logic       hit;
      logic [7:0] rbyte;
      logic       waccept;
      logic       htaken;
      logic       txv;
      logic [7:0] txb;
      logic       rx_room;
      logic       tx_pend;
   } uart_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_command = CMD_CPU_READ;
   logic [15:0] req_port_address = '0;
   logic        req_is_io_space = 1'b0;
   logic [7:0]  req_write_byte = '0;
   logic [7:0]  req_host_byte = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_decoded_hit;
   logic [7:0]  rsp_read_byte;
   logic        rsp_write_accepted;
   logic        rsp_host_byte_taken;
   logic        rsp_tx_valid;
   logic [7:0]  rsp_tx_byte;
   logic        rsp_rx_has_room;
   logic        rsp_tx_pending;

   uart_request_type pending_requests[$];
   uart_result_type  expected_results[$];
   int               mismatch_count = 0;
   int               sent_count = 0;
   int               rcvd_count = 0;
   int               req_idle_left = 0;
   int               rsp_stall_left = 0;

   logic [7:0] rx_store[DEPTH];
   logic [7:0] tx_store[DEPTH];
   int         rx_head = 0;
   int         rx_count = 0;
   int         tx_head = 0;
   int         tx_count = 0;
   logic       awaiting_newline = 1'b1;

   port_uart_with_fifos u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_command        (req_command),
      .req_port_address   (req_port_address),
      .req_is_io_space    (req_is_io_space),
      .req_write_byte     (req_write_byte),
      .req_host_byte      (req_host_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_decoded_hit    (rsp_decoded_hit),
      .rsp_read_byte      (rsp_read_byte),
      .rsp_write_accepted (rsp_write_accepted),
      .rsp_host_byte_taken(rsp_host_byte_taken),
      .rsp_tx_valid       (rsp_tx_valid),
      .rsp_tx_byte        (rsp_tx_byte),
      .rsp_rx_has_room    (rsp_rx_has_room),
      .rsp_tx_pending     (rsp_tx_pending)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   function automatic logic [7:0] uart_status();
      logic [7:0] s;
      s = '0;
      if (rx_count == 0) s |= STATUS_RX_EMPTY;
      else if (rx_count >= DEPTH) s |= STATUS_RX_FULL;
      if (tx_count == 0) s |= STATUS_TX_EMPTY;
      else if (tx_count >= DEPTH) s |= STATUS_TX_FULL;
      return s;
   endfunction

   function automatic uart_result_type predict_uart_result(uart_request_type r);
      uart_result_type res;
      logic            decoded;
      res = '0;
      decoded = r.io && (r.addr == PORT_STATUS || r.addr == PORT_DATA);
      case (r.cmd)
         CMD_CPU_READ: begin
            res.hit = decoded;
            if (!decoded) begin
               res.rbyte = READ_UNDECODED;
            end else if (r.addr == PORT_STATUS) begin
               res.rbyte = uart_status();
            end else if (rx_count > 0) begin
               res.rbyte = rx_store[rx_head];
               rx_head = (rx_head + 1) % DEPTH;
               rx_count--;
            end
         end
         CMD_CPU_WRITE: begin
            res.hit = decoded;
            if (decoded && r.addr == PORT_DATA && tx_count < DEPTH) begin
               tx_store[(tx_head + tx_count) % DEPTH] = r.wbyte;
               tx_count++;
               res.waccept = 1'b1;
            end
         end
         CMD_HOST_RX: begin
            if (rx_count < DEPTH) begin
               res.htaken = 1'b1;
               if (awaiting_newline) begin
                  if (r.hbyte == NEWLINE_BYTE) awaiting_newline = 1'b0;
               end else begin
                  rx_store[(rx_head + rx_count) % DEPTH] = r.hbyte;
                  rx_count++;
               end
            end
         end
         default: begin
            if (tx_count > 0) begin
               res.txb = tx_store[tx_head];
               tx_head = (tx_head + 1) % DEPTH;
               tx_count--;
               res.txv = 1'b1;
            end
         end
      endcase
      res.rx_room = (rx_count < DEPTH);
      res.tx_pend = (tx_count > 0);
      return res;
   endfunction

   function automatic void check_field(string what, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %h got %h", $time, what, want, got);
         mismatch_count++;
      end
   endfunction

   function automatic uart_request_type make_request(command_type cmd, logic [15:0] addr,
                                                     logic io, logic [7:0] wb,
                                                     logic [7:0] hb);
      uart_request_type r;
      r.cmd = cmd;
      r.addr = addr;
      r.io = io;
      r.wbyte = wb;
      r.hbyte = hb;
      r.hold_for_drain = 1'b0;
      return r;
   endfunction

   // driver
   always @(posedge clock) begin
      uart_request_type acc;
      uart_request_type nxt;
      logic             idling_on;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_ready) begin
         req_valid <= 1'b1;
      end else begin
         if (req_valid) begin
            acc = make_request(command_type'(req_command), req_port_address,
                               req_is_io_space, req_write_byte, req_host_byte);
            expected_results.push_back(predict_uart_result(acc));
            sent_count++;
         end
         idling_on = (pending_requests.size() > 150) && ((sent_count / 100) % 4 != 3);
         if (req_idle_left > 0) begin
            req_idle_left--;
            req_valid <= 1'b0;
         end else if (pending_requests.size() == 0) begin
            req_valid <= 1'b0;
         end else if (pending_requests[0].hold_for_drain && expected_results.size() != 0) begin
            req_valid <= 1'b0;
         end else if (idling_on && $urandom_range(0, 9) == 0) begin
            req_idle_left = $urandom_range(1, 17) - 1;
            req_valid <= 1'b0;
         end else begin
            nxt = pending_requests.pop_front();
            req_valid <= 1'b1;
            req_command <= nxt.cmd;
            req_port_address <= nxt.addr;
            req_is_io_space <= nxt.io;
            req_write_byte <= nxt.wbyte;
            req_host_byte <= nxt.hbyte;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      uart_result_type want;
      logic            stalls_on;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rcvd_count++;
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected item expected none got %h/%h", $time,
                        rsp_read_byte, rsp_tx_byte);
               mismatch_count++;
            end else begin
               want = expected_results.pop_front();
               check_field("decoded_hit", want.hit, rsp_decoded_hit);
               check_field("read_byte", want.rbyte, rsp_read_byte);
               check_field("write_accepted", want.waccept, rsp_write_accepted);
               check_field("host_byte_taken", want.htaken, rsp_host_byte_taken);
               check_field("tx_valid", want.txv, rsp_tx_valid);
               check_field("tx_byte", want.txb, rsp_tx_byte);
               check_field("rx_has_room", want.rx_room, rsp_rx_has_room);
               check_field("tx_pending", want.tx_pend, rsp_tx_pending);
            end
         end
         stalls_on = (pending_requests.size() > 150) && ((rcvd_count / 100) % 4 != 1);
         if (rsp_stall_left > 0) begin
            rsp_stall_left--;
            rsp_ready <= 1'b0;
         end else if (stalls_on && $urandom_range(0, 9) == 0) begin
            rsp_stall_left = $urandom_range(1, 17) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // stimulus
   initial begin
      uart_request_type r;
      int               mode;
      int               mode_left;
      int               pick;
      int               w_read;
      int               w_write;
      int               w_rx;
      mode = 0;
      mode_left = 0;
      // flush phase, undecoded accesses, empty FIFOs
      pending_requests.push_back(make_request(CMD_CPU_READ, PORT_STATUS, 1'b1, 8'h00, 8'h00));
      pending_requests.push_back(make_request(CMD_CPU_READ, PORT_DATA, 1'b1, 8'h00, 8'h00));
      pending_requests.push_back(make_request(CMD_CPU_READ, 16'h0042, 1'b1, 8'h00, 8'h00));
      pending_requests.push_back(make_request(CMD_CPU_READ, PORT_STATUS, 1'b0, 8'h00, 8'h00));
      pending_requests.push_back(make_request(CMD_CPU_READ, 16'hFFFF, 1'b1, 8'hFF, 8'hFF));
      pending_requests.push_back(make_request(CMD_CPU_WRITE, PORT_STATUS, 1'b1, 8'h5A, 8'h00));
      pending_requests.push_back(make_request(CMD_CPU_WRITE, PORT_DATA, 1'b0, 8'hA5, 8'h00));
      pending_requests.push_back(make_request(CMD_CPU_WRITE, 16'h0000, 1'b1, 8'h11, 8'h00));
      pending_requests.push_back(make_request(CMD_HOST_PULL, 16'h0000, 1'b0, 8'h00, 8'h00));
      pending_requests.push_back(make_request(CMD_HOST_RX, 16'h0000, 1'b0, 8'h00, 8'h41));
      pending_requests.push_back(make_request(CMD_HOST_RX, 16'hFFFF, 1'b1, 8'hFF, 8'hFF));
      pending_requests.push_back(make_request(CMD_HOST_RX, 16'h0000, 1'b0, 8'h00, NEWLINE_BYTE));
      pending_requests.push_back(make_request(CMD_HOST_RX, 16'h0000, 1'b0, 8'h00, 8'h00));
      pending_requests.push_back(make_request(CMD_HOST_RX, 16'h0000, 1'b0, 8'h00, NEWLINE_BYTE));
      pending_requests.push_back(make_request(CMD_HOST_RX, 16'h0000, 1'b0, 8'h00, 8'hFF));
      pending_requests.push_back(make_request(CMD_CPU_READ, PORT_STATUS, 1'b1, 8'h00, 8'h00));
      pending_requests.push_back(make_request(CMD_CPU_READ, PORT_DATA, 1'b1, 8'h00, 8'h00));
      pending_requests.push_back(make_request(CMD_CPU_READ, PORT_DATA, 1'b1, 8'h00, 8'h00));
      pending_requests.push_back(make_request(CMD_CPU_WRITE, PORT_DATA, 1'b1, 8'hFF, 8'h00));
      pending_requests.push_back(make_request(CMD_CPU_WRITE, PORT_DATA, 1'b1, 8'h00, 8'h00));
      pending_requests.push_back(make_request(CMD_CPU_READ, PORT_STATUS, 1'b1, 8'h00, 8'h00));
      pending_requests.push_back(make_request(CMD_HOST_PULL, 16'hFFFF, 1'b1, 8'hFF, 8'hFF));
      pending_requests.push_back(make_request(CMD_HOST_PULL, 16'h0000, 1'b0, 8'h00, 8'h00));
      pending_requests.push_back(make_request(CMD_HOST_PULL, 16'h0000, 1'b0, 8'h00, 8'h00));
      for (int n = 0; n < 1200; n++) begin
         if (mode_left == 0) begin
            mode = $urandom_range(0, 2);
            mode_left = $urandom_range(20, 60);
         end
         mode_left--;
         case (mode)
            0: begin w_read = 10; w_write = 50; w_rx = 90; end
            1: begin w_read = 40; w_write = 50; w_rx = 60; end
            default: begin w_read = 25; w_write = 50; w_rx = 75; end
         endcase
         if ($urandom_range(0, 9) == 0) begin
            r = make_request(command_type'($urandom_range(0, 3)), 16'($urandom),
                             1'($urandom), 8'($urandom), 8'($urandom));
         end else begin
            pick = $urandom_range(0, 99);
            r = make_request(CMD_HOST_PULL, PORT_DATA, 1'b1, 8'($urandom), 8'($urandom));
            if (pick < w_read) r.cmd = CMD_CPU_READ;
            else if (pick < w_write) r.cmd = CMD_CPU_WRITE;
            else if (pick < w_rx) r.cmd = CMD_HOST_RX;
            if ($urandom_range(0, 4) == 0) r.addr = PORT_STATUS;
            if ($urandom_range(0, 15) == 0) r.hbyte = NEWLINE_BYTE;
         end
         r.hold_for_drain = (n == 600);
         pending_requests.push_back(r);
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      while (pending_requests.size() != 0 || req_valid || expected_results.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #1000000;
      $display("Mismatches found");
      $finish;
   end

endmodule
